// ----- rtl/frustum_box_classifier_top_defines.svh -----
// ----------------------------------------------------------------------------
// Frustum box classifier assertion macros
// Shared property forms for the checks in the top level.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CLASSIFIER_TOP_DEFINES_SVH
`define FRUSTUM_BOX_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define FBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define FBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Frustum box classifier package
// Sizes, codes, chain link type and field conversion shared by all modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbc_pkg;

  localparam int PLANE_COUNT  = 6;
  localparam int COORD_WIDTH  = 32;
  localparam int FIELD_WIDTH  = 32;
  localparam int INDEX_WIDTH  = 3;
  localparam int PROD_WIDTH   = 2 * COORD_WIDTH;
  localparam int SUM_WIDTH    = 2 * COORD_WIDTH + 2;
  localparam int OFFSET_SHIFT = 16;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_TEST = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_OUT   = 2'd0,
    VERDICT_IN    = 2'd1,
    VERDICT_CROSS = 2'd2
  } verdict_e;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic   valid;
    logic   any_out;
    logic   all_in;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } cell_link_t;

  function automatic coord_t to_coord(logic [FIELD_WIDTH-1:0] raw);
    return coord_t'(raw[COORD_WIDTH-1:0]);
  endfunction

endpackage

// ----- rtl/fbc_cell.sv -----
// ----------------------------------------------------------------------------
// Frustum box classifier plane cell
// Holds one plane, tests the passing box against it in two stages
// (products, then sum and sign) and hands the box on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  fbc_pkg::coord_t    nx_i,
  input  fbc_pkg::coord_t    ny_i,
  input  fbc_pkg::coord_t    nz_i,
  input  fbc_pkg::coord_t    d_i,
  input  fbc_pkg::cell_link_t link_i,
  output fbc_pkg::cell_link_t link_o
);
  import fbc_pkg::*;

  coord_t nx_q, ny_q, nz_q, d_q;

  coord_t pos_x, pos_y, pos_z, neg_x, neg_y, neg_z;
  logic signed [PROD_WIDTH-1:0] pp_x_d, pp_y_d, pp_z_d, np_x_d, np_y_d, np_z_d;
  logic signed [PROD_WIDTH-1:0] pp_x_q, pp_y_q, pp_z_q, np_x_q, np_y_q, np_z_q;
  cell_link_t s1_q;

  logic signed [SUM_WIDTH-1:0] off_term, sum_pos, sum_neg;
  cell_link_t link_d, link_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q <= '0;
      ny_q <= '0;
      nz_q <= '0;
      d_q  <= '0;
    end else if (we_i) begin
      nx_q <= nx_i;
      ny_q <= ny_i;
      nz_q <= nz_i;
      d_q  <= d_i;
    end
  end

  always_comb begin
    pos_x  = nx_q[COORD_WIDTH-1] ? link_i.min_x : link_i.max_x;
    pos_y  = ny_q[COORD_WIDTH-1] ? link_i.min_y : link_i.max_y;
    pos_z  = nz_q[COORD_WIDTH-1] ? link_i.min_z : link_i.max_z;
    neg_x  = nx_q[COORD_WIDTH-1] ? link_i.max_x : link_i.min_x;
    neg_y  = ny_q[COORD_WIDTH-1] ? link_i.max_y : link_i.min_y;
    neg_z  = nz_q[COORD_WIDTH-1] ? link_i.max_z : link_i.min_z;
    pp_x_d = nx_q * pos_x;
    pp_y_d = ny_q * pos_y;
    pp_z_d = nz_q * pos_z;
    np_x_d = nx_q * neg_x;
    np_y_d = ny_q * neg_y;
    np_z_d = nz_q * neg_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= link_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_x_q <= pp_x_d;
    pp_y_q <= pp_y_d;
    pp_z_q <= pp_z_d;
    np_x_q <= np_x_d;
    np_y_q <= np_y_d;
    np_z_q <= np_z_d;
  end

  always_comb begin
    off_term       = SUM_WIDTH'(d_q) <<< OFFSET_SHIFT;
    sum_pos        = SUM_WIDTH'(pp_x_q) + SUM_WIDTH'(pp_y_q) + SUM_WIDTH'(pp_z_q) + off_term;
    sum_neg        = SUM_WIDTH'(np_x_q) + SUM_WIDTH'(np_y_q) + SUM_WIDTH'(np_z_q) + off_term;
    link_d         = s1_q;
    link_d.any_out = s1_q.any_out | sum_pos[SUM_WIDTH-1];
    link_d.all_in  = s1_q.all_in & ~sum_neg[SUM_WIDTH-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

// ----- rtl/frustum_box_classifier_top.sv -----
// ----------------------------------------------------------------------------
// Frustum box classifier
// Positive/negative vertex test of an axis-aligned box against a row of
// plane cells, one plane per cell, with exact wide distance sums.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_ready_o | action, plane index, plane, box
//   out     | output    | out_valid_o / out_ready_i | verdict
//
// A load request writes the addressed cell's plane.
// A test request runs down the cell row, through each cell's multiply stage and
// then its sum and sign stage, before its verdict enters the output register.
// One test is in flight at a time; in_ready_o is low from a test accept until
// its verdict enters the output register. A stalled verdict waits in a hold
// register while the output register is full. Reset clears all planes to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frustum_box_classifier_top_defines.svh"

module frustum_box_classifier_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             action_i,
  input  logic [fbc_pkg::INDEX_WIDTH-1:0]  plane_index_i,
  input  logic [fbc_pkg::FIELD_WIDTH-1:0]  normal_x_i,
  input  logic [fbc_pkg::FIELD_WIDTH-1:0]  normal_y_i,
  input  logic [fbc_pkg::FIELD_WIDTH-1:0]  normal_z_i,
  input  logic [fbc_pkg::FIELD_WIDTH-1:0]  plane_offset_i,
  input  logic [fbc_pkg::FIELD_WIDTH-1:0]  box_min_x_i,
  input  logic [fbc_pkg::FIELD_WIDTH-1:0]  box_min_y_i,
  input  logic [fbc_pkg::FIELD_WIDTH-1:0]  box_min_z_i,
  input  logic [fbc_pkg::FIELD_WIDTH-1:0]  box_max_x_i,
  input  logic [fbc_pkg::FIELD_WIDTH-1:0]  box_max_y_i,
  input  logic [fbc_pkg::FIELD_WIDTH-1:0]  box_max_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       verdict_o
);
  import fbc_pkg::*;

  logic in_acc, test_acc, load_acc;
  coord_t nx_c, ny_c, nz_c, d_c;
  cell_link_t link [PLANE_COUNT+1];

  logic end_valid, res_valid, out_load;
  verdict_e end_verdict, res_verdict;

  logic     busy_q, busy_d;
  logic     pend_q, pend_d;
  verdict_e pend_verdict_q;
  logic     out_valid_q, out_valid_d;
  verdict_e out_verdict_q;

  assign in_ready_o = ~busy_q;
  assign in_acc     = in_valid_i & in_ready_o;
  assign test_acc   = in_acc & (action_i == ACTION_TEST);
  assign load_acc   = in_acc & (action_i == ACTION_LOAD);

  assign nx_c = to_coord(normal_x_i);
  assign ny_c = to_coord(normal_y_i);
  assign nz_c = to_coord(normal_z_i);
  assign d_c  = to_coord(plane_offset_i);

  always_comb begin
    link[0].valid   = test_acc;
    link[0].any_out = 1'b0;
    link[0].all_in  = 1'b1;
    link[0].min_x   = to_coord(box_min_x_i);
    link[0].min_y   = to_coord(box_min_y_i);
    link[0].min_z   = to_coord(box_min_z_i);
    link[0].max_x   = to_coord(box_max_x_i);
    link[0].max_y   = to_coord(box_max_y_i);
    link[0].max_z   = to_coord(box_max_z_i);
  end

  for (genvar gi = 0; gi < PLANE_COUNT; gi++) begin : g_cell
    fbc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .we_i   (load_acc && (plane_index_i == INDEX_WIDTH'(gi))),
      .nx_i   (nx_c),
      .ny_i   (ny_c),
      .nz_i   (nz_c),
      .d_i    (d_c),
      .link_i (link[gi]),
      .link_o (link[gi+1])
    );
  end

  always_comb begin
    end_valid = link[PLANE_COUNT].valid;
    priority if (link[PLANE_COUNT].any_out) begin
      end_verdict = VERDICT_OUT;
    end else if (link[PLANE_COUNT].all_in) begin
      end_verdict = VERDICT_IN;
    end else begin
      end_verdict = VERDICT_CROSS;
    end

    res_valid   = end_valid | pend_q;
    res_verdict = pend_q ? pend_verdict_q : end_verdict;
    out_load    = res_valid & (~out_valid_q | out_ready_i);

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    if (end_valid & ~out_load) begin
      pend_d = 1'b1;
    end else if (out_load) begin
      pend_d = 1'b0;
    end else begin
      pend_d = pend_q;
    end

    if (test_acc) begin
      busy_d = 1'b1;
    end else if (out_load) begin
      busy_d = 1'b0;
    end else begin
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_valid & ~out_load) begin
      pend_verdict_q <= end_verdict;
    end
    if (out_load) begin
      out_verdict_q <= res_verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_verdict_q;

  `FBC_ASSERT_NOW(a_pend_busy, pend_q, busy_q, "held verdict without a test in flight")
  `FBC_ASSERT_NOW(a_end_busy, end_valid, busy_q && !pend_q, "chain result while idle or held")
  `FBC_ASSERT_NEXT(a_test_busy, test_acc, busy_q, "test request did not mark busy")
  `FBC_ASSERT_NEXT(a_load_idle, load_acc, !busy_q, "load request left block busy")

endmodule
